// File: rtl/core/ppra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page refcount allocator.
// No dependencies; imported by every other file of the block.
package ppra_pkg;

  localparam int MAX_PAGES_DEF = 4096;
  localparam int PG_SHIFT      = 12;
  localparam int REG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CNT_W         = 8;
  localparam int ADDR_W        = 32;
  localparam int PADDR_W       = 24;
  localparam int STATUS_W      = 2;
  localparam int PG_IDX_W      = ADDR_W - PG_SHIFT;

  localparam logic [REG_W-1:0] FIRST_PAGE_RST = 13'd256;
  localparam logic [REG_W-1:0] PAGE_COUNT_RST = 13'd4096;
  localparam logic [REG_W-1:0] FREE_MAX       = '1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL_CHK,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic inc;
    logic dec;
  } free_upd_t;

endpackage

// File: rtl/core/ppra_ifs.sv
`timescale 1ns / 1ps
// Request, response and configuration channel interfaces.
// Depends on ppra_pkg for field widths.
interface ppra_in_if;
  import ppra_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] release_addr;
  modport source (output valid, mode, release_addr, input ready);
  modport sink   (input valid, mode, release_addr, output ready);
endinterface

interface ppra_out_if;
  import ppra_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PADDR_W-1:0]  page_addr;
  logic [REG_W-1:0]    free_left;
  modport source (output valid, status, page_addr, free_left, input ready);
  modport sink   (input valid, status, page_addr, free_left, output ready);
endinterface

interface ppra_cfg_if;
  import ppra_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/physical_page_refcount_allocator_unit.sv
`timescale 1ns / 1ps
// Physical page-frame allocator with per-page reference counts.
// Depends on ppra_pkg, the channel interfaces, ppra_cnt_mem, ppra_regs, ppra_ctrl.
//
// in_req carries one request: mode 0 allocates the first free page at or above
// first_page, mode 1 releases the page at release_addr. out_rsp returns one
// response per request: status, page_addr and the free-page count after it.
// cfg_wr writes first_page (index 0) or page_count (index 1); it is always
// ready and reloads the free-page counter. Write it only while no request is
// in flight.
// An allocation scans the count store one page per cycle, probing up to the
// page limit minus first_page pages. A release reads the count, then
// decrements it unless it is zero; a rejected release skips the read.
// One request is worked on at a time; the next is taken once the response
// sits in the output register, even if the receiver has not taken it yet.
// After reset a clearing pass zeroes every count store entry, with in_req.ready
// low while it runs. A stalled receiver holds the response; the block then
// finishes at most one more request and waits until the register frees.
module physical_page_refcount_allocator_unit #(
  parameter int MAX_PAGES = ppra_pkg::MAX_PAGES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ppra_in_if.sink     in_req,
  ppra_out_if.source  out_rsp,
  ppra_cfg_if.sink    cfg_wr
);
  import ppra_pkg::*;

  localparam int IDXW = $clog2(MAX_PAGES);
  localparam int CW   = (IDXW + 1 > REG_W) ? IDXW + 1 : REG_W;

  logic [REG_W-1:0] first_page;
  logic [CW-1:0]    lim;
  logic [REG_W-1:0] free_left;
  free_upd_t        upd;
  logic             wr_en;
  logic [IDXW-1:0]  wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic             rd_en;
  logic [IDXW-1:0]  rd_addr;
  logic [CNT_W-1:0] rd_data;

  ppra_regs #(
    .MAX_PAGES (MAX_PAGES),
    .CW        (CW)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .upd        (upd),
    .first_page (first_page),
    .lim        (lim),
    .free_left  (free_left)
  );

  ppra_cnt_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (IDXW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppra_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .IDXW      (IDXW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .first_page (first_page),
    .lim        (lim),
    .free_left  (free_left),
    .upd        (upd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

endmodule

// File: rtl/core/ppra_cnt_mem.sv
`timescale 1ns / 1ps
// Reference count store: one write port, one read port, registered read data.
// Depends on ppra_pkg.
module ppra_cnt_mem #(
  parameter int DEPTH = ppra_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(ppra_pkg::MAX_PAGES_DEF)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [ppra_pkg::CNT_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [ppra_pkg::CNT_W-1:0] rd_data
);
  import ppra_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ppra_regs.sv
`timescale 1ns / 1ps
// Configuration registers, page limit and saturating free-page counter.
// Depends on ppra_pkg and ppra_cfg_if.
module ppra_regs #(
  parameter int MAX_PAGES = ppra_pkg::MAX_PAGES_DEF,
  parameter int CW        = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ppra_cfg_if.sink                   cfg_wr,
  input  ppra_pkg::free_upd_t        upd,
  output logic [ppra_pkg::REG_W-1:0] first_page,
  output logic [CW-1:0]              lim,
  output logic [ppra_pkg::REG_W-1:0] free_left
);
  import ppra_pkg::*;

  localparam int RST_LIM  = (int'(PAGE_COUNT_RST) > MAX_PAGES) ? MAX_PAGES
                                                               : int'(PAGE_COUNT_RST);
  localparam int RST_FREE = (RST_LIM > int'(FIRST_PAGE_RST)) ?
                            RST_LIM - int'(FIRST_PAGE_RST) : 0;

  logic [REG_W-1:0] first_r, first_nxt;
  logic [REG_W-1:0] count_r, count_nxt;
  logic [REG_W-1:0] free_r, free_nxt;

  function automatic logic [CW-1:0] clamp_lim(input logic [REG_W-1:0] cnt);
    logic [CW-1:0] c;
    c = CW'(cnt);
    return (c > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : c;
  endfunction

  function automatic logic [REG_W-1:0] reload(input logic [REG_W-1:0] fp,
                                              input logic [REG_W-1:0] cnt);
    logic [CW-1:0] l;
    logic [CW-1:0] f;
    l = clamp_lim(cnt);
    f = CW'(fp);
    return (l > f) ? REG_W'(l - f) : '0;
  endfunction

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    free_nxt  = free_r;
    if (upd.dec && free_r != '0) begin
      free_nxt = free_r - REG_W'(1);
    end else if (upd.inc && free_r != FREE_MAX) begin
      free_nxt = free_r + REG_W'(1);
    end
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_FIRST_PAGE: begin
          first_nxt = cfg_wr.data;
          free_nxt  = reload(cfg_wr.data, count_r);
        end
        REG_PAGE_COUNT: begin
          count_nxt = cfg_wr.data;
          free_nxt  = reload(first_r, cfg_wr.data);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= FIRST_PAGE_RST;
      count_r <= PAGE_COUNT_RST;
      free_r  <= REG_W'(RST_FREE);
    end else begin
      first_r <= first_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
    end
  end

  assign first_page = first_r;
  assign lim        = clamp_lim(count_r);
  assign free_left  = free_r;

endmodule

// File: rtl/core/ppra_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: clearing pass, first-fit scan, release read-modify-write,
// response register. Depends on ppra_pkg and the channel interfaces.
module ppra_ctrl #(
  parameter int MAX_PAGES = ppra_pkg::MAX_PAGES_DEF,
  parameter int IDXW      = $clog2(ppra_pkg::MAX_PAGES_DEF),
  parameter int CW        = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ppra_in_if.sink                    in_req,
  ppra_out_if.source                 out_rsp,
  input  logic [ppra_pkg::REG_W-1:0] first_page,
  input  logic [CW-1:0]              lim,
  input  logic [ppra_pkg::REG_W-1:0] free_left,
  output ppra_pkg::free_upd_t        upd,
  output logic                       wr_en,
  output logic [IDXW-1:0]            wr_addr,
  output logic [ppra_pkg::CNT_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [IDXW-1:0]            rd_addr,
  input  logic [ppra_pkg::CNT_W-1:0] rd_data
);
  import ppra_pkg::*;

  localparam int CMPW = (CW > PG_IDX_W) ? CW : PG_IDX_W;
  localparam int PW   = (IDXW > PG_SHIFT) ? IDXW : PG_SHIFT;

  state_t state_r, state_nxt;

  logic [CW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                probe_vld_r, probe_vld_nxt;
  logic [IDXW-1:0]     probe_idx_r, probe_idx_nxt;
  logic [IDXW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [IDXW-1:0]     rel_idx_r, rel_idx_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [PADDR_W-1:0]  res_paddr_r, res_paddr_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PADDR_W-1:0]  out_paddr_r, out_paddr_nxt;
  logic [REG_W-1:0]    out_free_r, out_free_nxt;

  logic                accept;
  logic [PG_IDX_W-1:0] rel_pg;
  logic                rel_bad;
  logic                found;
  logic                issue;
  logic                slot_free;
  logic                clr_last;
  logic [PW-1:0]       probe_ext;

  assign accept    = in_req.valid && in_req.ready;
  assign rel_pg    = in_req.release_addr[ADDR_W-1:PG_SHIFT];
  assign rel_bad   = (in_req.release_addr[PG_SHIFT-1:0] != '0)
                  || (CMPW'(rel_pg) < CMPW'(first_page))
                  || (CMPW'(rel_pg) >= CMPW'(lim));
  assign found     = probe_vld_r && (rd_data == '0);
  assign issue     = scan_addr_r < lim;
  assign slot_free = !out_vld_r || out_rsp.ready;
  assign clr_last  = clr_addr_r == IDXW'(MAX_PAGES - 1);
  assign probe_ext = PW'(probe_idx_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req.mode) begin
            state_nxt = rel_bad ? S_PUSH : S_REL_CHK;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (found || !issue) begin
          state_nxt = S_PUSH;
        end
      end
      S_REL_CHK: state_nxt = S_PUSH;
      S_PUSH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    scan_addr_nxt  = scan_addr_r;
    probe_vld_nxt  = probe_vld_r;
    probe_idx_nxt  = probe_idx_r;
    clr_addr_nxt   = clr_addr_r;
    rel_idx_nxt    = rel_idx_r;
    res_status_nxt = res_status_r;
    res_paddr_nxt  = res_paddr_r;
    out_vld_nxt    = out_vld_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_paddr_nxt  = out_paddr_r;
    out_free_nxt   = out_free_r;
    upd            = '0;
    wr_en          = 1'b0;
    wr_addr        = probe_idx_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = scan_addr_r[IDXW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + IDXW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          res_paddr_nxt = '0;
          if (in_req.mode) begin
            rel_idx_nxt = rel_pg[IDXW-1:0];
            if (rel_bad) begin
              res_status_nxt = ST_BAD_ADDR;
            end else begin
              rd_en   = 1'b1;
              rd_addr = rel_pg[IDXW-1:0];
            end
          end else begin
            scan_addr_nxt = CW'(first_page);
            probe_vld_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          wr_en          = 1'b1;
          wr_addr        = probe_idx_r;
          wr_data        = CNT_W'(1);
          upd.dec        = 1'b1;
          res_status_nxt = ST_OK;
          res_paddr_nxt  = {probe_ext[PG_SHIFT-1:0], PG_SHIFT'(0)};
        end else if (issue) begin
          rd_en         = 1'b1;
          rd_addr       = scan_addr_r[IDXW-1:0];
          scan_addr_nxt = scan_addr_r + CW'(1);
          probe_vld_nxt = 1'b1;
          probe_idx_nxt = scan_addr_r[IDXW-1:0];
        end else begin
          res_status_nxt = ST_OOM;
          res_paddr_nxt  = '0;
        end
      end
      S_REL_CHK: begin
        if (rd_data == '0) begin
          res_status_nxt = ST_NOT_USED;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = rel_idx_r;
          wr_data        = rd_data - CNT_W'(1);
          upd.inc        = rd_data == CNT_W'(1);
          res_status_nxt = ST_OK;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_paddr_nxt  = res_paddr_r;
          out_free_nxt   = free_left;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      probe_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      probe_vld_r <= probe_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    probe_idx_r  <= probe_idx_nxt;
    rel_idx_r    <= rel_idx_nxt;
    res_status_r <= res_status_nxt;
    res_paddr_r  <= res_paddr_nxt;
    out_status_r <= out_status_nxt;
    out_paddr_r  <= out_paddr_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign in_req.ready      = state_r == S_IDLE;
  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.page_addr = out_paddr_r;
  assign out_rsp.free_left = out_free_r;

endmodule
